@@ sv/som_bmu_search_and_update_unit_defines.svh @@
// Assertion macros shared by the self-organizing map block.
// Include guarded; used by the controller and the top level.
`ifndef SOM_BMU_SEARCH_AND_UPDATE_UNIT_DEFINES_SVH
`define SOM_BMU_SEARCH_AND_UPDATE_UNIT_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define SOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define SOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/som_pkg.sv @@
// Shared types, constants and the neighborhood table of the map block.
// No dependencies.
`default_nettype none
package som_pkg;
  localparam int unsigned DistW = 36;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // Grid and vector size limits; the field widths below are sized for them.
  localparam int unsigned MaxRows = 16;
  localparam int unsigned MaxCols = 16;
  localparam int unsigned MaxDim  = 16;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_TRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ROWS  = 3'd0,
    REG_COLS  = 3'd1,
    REG_DIM   = 3'd2,
    REG_ITERS = 3'd3,
    REG_DECAY = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_S_RD,
    ST_S_ACC,
    ST_S_CMP,
    ST_U_THETA,
    ST_U_MUL,
    ST_U_RD,
    ST_U_DIFF,
    ST_U_STEP,
    ST_U_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  unit_index;
    logic [3:0]  element_index;
    logic signed [15:0] value;
    logic [15:0] iteration;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [3:0]  bmu_row;
    logic [3:0]  bmu_col;
    logic [35:0] bmu_distance_sq;
    logic        weights_updated;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;    // latch request fields
    logic store_in;   // perform weight write or observation store
    logic div_start;  // begin alpha division
    logic div_step;
    logic clr_pos;    // reset unit and element counters
    logic rd;         // issue memory read at current position
    logic acc_clr;
    logic acc_add;
    logic cmp;        // compare unit distance with best
    logic theta;      // register neighborhood factor
    logic mul;        // register theta*alpha factor
    logic diff;
    logic step;
    logic wr;         // write updated weight
    logic adv_elem;
    logic adv_unit;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic cmd_valid_search; // eval or train command
    logic is_train;
    logic last;
    logic div_done;
    logic elem_last;
    logic unit_last;
  } sts_t;

  function automatic logic [15:0] theta_lut(input logic [8:0] d2);
    logic [15:0] r;
    case (d2)
      9'd0:  r = 16'd26145; 9'd1:  r = 16'd15858; 9'd2:  r = 16'd9618;
      9'd3:  r = 16'd5834;  9'd4:  r = 16'd3538;  9'd5:  r = 16'd2146;
      9'd6:  r = 16'd1302;  9'd7:  r = 16'd790;   9'd8:  r = 16'd479;
      9'd9:  r = 16'd290;   9'd10: r = 16'd176;   9'd11: r = 16'd107;
      9'd12: r = 16'd65;    9'd13: r = 16'd39;    9'd14: r = 16'd24;
      9'd15: r = 16'd14;    9'd16: r = 16'd9;     9'd17: r = 16'd5;
      9'd18: r = 16'd3;     9'd19: r = 16'd2;     9'd20: r = 16'd1;
      9'd21: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/som_ctrl.sv @@
// Controller state machine of the map block: sequences search and update.
// Depends on som_pkg and the shared assertion macros.
`default_nettype none
`include "som_bmu_search_and_update_unit_defines.svh"
module som_ctrl import som_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  sts_t      sts_i,
  output logic      busy_o,
  output ctl_t      ctl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ST_IDLE captures the request in the cycle it is accepted; ST_ALPHA stores it and
  // starts the search for a final eval or train element, a train one once alpha is done.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ALPHA;
        end
      end
      ST_ALPHA: begin
        if (!(sts_i.cmd_valid_search && sts_i.last)) begin
          state_d = ST_IDLE;
        end else if (!sts_i.is_train || sts_i.div_done) begin
          state_d = ST_S_RD;
        end
      end
      ST_S_RD:  state_d = ST_S_ACC;
      ST_S_ACC: state_d = sts_i.elem_last ? ST_S_CMP : ST_S_RD;
      ST_S_CMP: begin
        if (!sts_i.unit_last) begin
          state_d = ST_S_RD;
        end else if (sts_i.is_train) begin
          state_d = ST_U_THETA;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_U_THETA: state_d = ST_U_MUL;
      ST_U_MUL:   state_d = ST_U_RD;
      ST_U_RD:    state_d = ST_U_DIFF;
      ST_U_DIFF:  state_d = ST_U_STEP;
      ST_U_STEP:  state_d = ST_U_WR;
      ST_U_WR: begin
        if (!sts_i.elem_last) begin
          state_d = ST_U_RD;
        end else if (!sts_i.unit_last) begin
          state_d = ST_U_THETA;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        ctl_o.capture = start_i;
      end
      ST_ALPHA: begin
        ctl_o.store_in = 1'b1;
        ctl_o.div_step = 1'b1;
        ctl_o.clr_pos = 1'b1;
        ctl_o.acc_clr = 1'b1;
      end
      ST_S_RD:  ctl_o.rd = 1'b1;
      ST_S_ACC: begin
        ctl_o.acc_add = 1'b1;
        ctl_o.adv_elem = 1'b1;
      end
      ST_S_CMP: begin
        ctl_o.cmp = 1'b1;
        ctl_o.acc_clr = 1'b1;
        ctl_o.adv_unit = 1'b1;
        ctl_o.div_step = 1'b1;
      end
      ST_U_THETA: ctl_o.theta = 1'b1;
      ST_U_MUL:   ctl_o.mul = 1'b1;
      ST_U_RD:    ctl_o.rd = 1'b1;
      ST_U_DIFF:  ctl_o.diff = 1'b1;
      ST_U_STEP:  ctl_o.step = 1'b1;
      ST_U_WR: begin
        ctl_o.wr = 1'b1;
        ctl_o.adv_elem = 1'b1;
        ctl_o.adv_unit = sts_i.elem_last;
      end
      ST_DONE: ctl_o.emit = 1'b1;
      default: ctl_o = '0;
    endcase
    ctl_o.div_start = ctl_o.capture;
  end

  `SOM_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o,
    "accepted request did not raise busy")
  `SOM_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, state_q == ST_DONE, !busy_o,
    "controller did not return to idle after result")
  `SOM_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1,
    !(ctl_o.rd && ctl_o.wr), "read and write commanded together")
endmodule
`default_nettype wire

@@ sv/som_dp.sv @@
// Datapath of the map block: weight memory, distance accumulator,
// best-unit registers, alpha divider and saturating weight update.
// Depends on som_pkg.
`default_nettype none
module som_dp import som_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  req_t      req_i,
  input  logic [4:0]  rows_i,
  input  logic [4:0]  cols_i,
  input  logic [4:0]  dim_i,
  input  logic [15:0] iters_i,
  input  logic [15:0] decay_i,
  input  ctl_t      ctl_i,
  output sts_t      sts_o,
  output rsp_t      rsp_o
);
  localparam int unsigned Units = MaxRows * MaxCols;
  localparam int unsigned Depth = Units * MaxDim;
  localparam int unsigned UW = (Units > 1) ? $clog2(Units) : 1;
  localparam int unsigned EW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t req_q;
  // Clamped sizes.
  logic [4:0] rows, cols, dim;
  always_comb begin
    rows = (rows_i == 5'd0) ? 5'd1 : rows_i;
    cols = (cols_i == 5'd0) ? 5'd1 : cols_i;
    dim  = (dim_i  == 5'd0) ? 5'd1 : dim_i;
    if (32'(rows) > MaxRows) rows = 5'(MaxRows);
    if (32'(cols) > MaxCols) cols = 5'(MaxCols);
    if (32'(dim)  > MaxDim)  dim  = 5'(MaxDim);
  end

  logic signed [15:0] mem_q [Depth];
  logic signed [15:0] obs_q [MaxDim];
  logic signed [15:0] rd_q;

  logic [3:0] r_q, c_q;
  logic [4:0] e_q;
  logic [UW:0] unit_q;
  logic [4:0] br_q, bc_q;
  logic [DistW-1:0] acc_q, best_q;

  logic [AW-1:0] wr_addr, rd_addr;
  logic [9:0] wr_unit;
  logic do_wr_req, do_wr_upd;
  logic signed [15:0] new_w_q;

  assign wr_unit = {2'b0, req_q.unit_index};
  assign do_wr_req = ctl_i.store_in && (req_q.cmd == CMD_WRITE)
    && (wr_unit < 10'(rows) * 10'(cols)) && ({1'b0, req_q.element_index} < dim);
  assign wr_addr = do_wr_req ? AW'(32'(req_q.unit_index) * MaxDim + 32'(req_q.element_index))
                             : AW'(32'(unit_q) * MaxDim + 32'(e_q));
  assign rd_addr = AW'(32'(unit_q) * MaxDim + 32'(e_q));
  assign do_wr_upd = ctl_i.wr;

  always_ff @(posedge clk_i) begin
    if (do_wr_req) begin
      mem_q[wr_addr] <= req_q.value;
    end else if (do_wr_upd) begin
      mem_q[wr_addr] <= new_w_q;
    end
    if (ctl_i.rd) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      req_q <= req_i;
    end
    if (ctl_i.store_in && (req_q.cmd == CMD_EVAL || req_q.cmd == CMD_TRAIN)
        && ({1'b0, req_q.element_index} < dim)) begin
      obs_q[EW'(req_q.element_index)] <= req_q.value;
    end
  end

  // Distance term of one element.
  logic signed [16:0] sdiff;
  logic [16:0] mag;
  logic [33:0] sq;
  logic [DistW:0] sum;
  assign sdiff = 17'(obs_q[EW'(e_q)]) - 17'(rd_q);
  assign mag = sdiff[16] ? 17'(-sdiff) : sdiff;
  assign sq = 34'(mag) * 34'(mag);
  assign sum = {1'b0, acc_q} + (DistW+1)'(sq);

  // Position counters; the unit number is row-major over the grid in use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0; c_q <= '0; e_q <= '0; unit_q <= '0;
      acc_q <= '0; best_q <= '0; br_q <= '0; bc_q <= '0;
    end else begin
      if (ctl_i.clr_pos) begin
        r_q <= '0; c_q <= '0; e_q <= '0; unit_q <= '0;
      end else begin
        if (ctl_i.adv_elem) begin
          e_q <= (e_q + 5'd1 == dim) ? 5'd0 : e_q + 5'd1;
        end
        if (ctl_i.adv_unit) begin
          if ({1'b0, c_q} + 5'd1 == cols) begin
            c_q <= '0;
            r_q <= ({1'b0, r_q} + 5'd1 == rows) ? 4'd0 : r_q + 4'd1;
            unit_q <= ({1'b0, r_q} + 5'd1 == rows) ? '0 : unit_q + 1'b1;
          end else begin
            c_q <= c_q + 4'd1;
            unit_q <= unit_q + 1'b1;
          end
        end
      end
      if (ctl_i.acc_clr) begin
        acc_q <= '0;
      end else if (ctl_i.acc_add) begin
        acc_q <= sum[DistW] ? DistMax : sum[DistW-1:0];
      end
      if (ctl_i.cmp && ((unit_q == '0) || (acc_q < best_q))) begin
        best_q <= acc_q;
        br_q <= {1'b0, r_q};
        bc_q <= {1'b0, c_q};
      end
    end
  end

  // Restoring divider for floor(65536*(T-t)/T), one quotient bit per cycle while div_step is set.
  logic [15:0] tt;
  logic [16:0] rem_q;
  logic [15:0] quo_q;
  logic [4:0] dcnt_q;
  logic [17:0] trial;
  logic [15:0] alpha;
  assign tt = (iters_i == 16'd0) ? 16'd1 : iters_i;
  assign trial = {rem_q, 1'b0} - {2'b0, tt};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
    end else if (ctl_i.div_start) begin
      rem_q <= (req_i.iteration >= tt) ? 17'd0 : 17'(tt - req_i.iteration);
      quo_q <= '0;
      dcnt_q <= 5'd16;
    end else if (ctl_i.div_step && dcnt_q != 5'd0) begin
      dcnt_q <= dcnt_q - 5'd1;
      if (!trial[17]) begin
        rem_q <= trial[16:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= {rem_q[15:0], 1'b0};
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
  end
  // (T-t) <= T; at t = 0 every quotient bit is set, so the quotient saturates at 16'hffff.
  assign alpha = (decay_i != 16'd0) ? decay_i : quo_q;

  // Update path.
  logic [3:0] dr, dc;
  logic [15:0] theta_q;
  logic [16:0] m_q;
  logic [31:0] ta;
  logic signed [16:0] udiff_q;
  logic [33:0] prod;
  logic [17:0] s;
  logic signed [17:0] nw;
  assign dr = (r_q > br_q[3:0]) ? r_q - br_q[3:0] : br_q[3:0] - r_q;
  assign dc = (c_q > bc_q[3:0]) ? c_q - bc_q[3:0] : bc_q[3:0] - c_q;
  assign ta = 32'(theta_q) * 32'(alpha);
  assign prod = 34'(udiff_q[16] ? 17'(-udiff_q) : udiff_q) * 34'(m_q);
  assign s = 18'((prod + 34'd32768) >> 16);
  assign nw = udiff_q[16] ? 18'(rd_q) - $signed(s) : 18'(rd_q) + $signed(s);

  always_ff @(posedge clk_i) begin
    if (ctl_i.theta) begin
      theta_q <= theta_lut(9'(dr) * 9'(dr) + 9'(dc) * 9'(dc));
    end
    if (ctl_i.mul) begin
      m_q <= 17'((33'(ta) + 33'd32768) >> 16);
    end
    if (ctl_i.diff) begin
      udiff_q <= sdiff;
    end
    if (ctl_i.step) begin
      if (nw > 18'sd32767) begin
        new_w_q <= 16'sh7fff;
      end else if (nw < -18'sd32768) begin
        new_w_q <= 16'sh8000;
      end else begin
        new_w_q <= nw[15:0];
      end
    end
  end

  assign sts_o.cmd_valid_search = (req_q.cmd == CMD_EVAL) || (req_q.cmd == CMD_TRAIN);
  assign sts_o.is_train = (req_q.cmd == CMD_TRAIN);
  assign sts_o.last = req_q.last;
  assign sts_o.div_done = (dcnt_q == 5'd0);
  assign sts_o.elem_last = (e_q + 5'd1 == dim);
  assign sts_o.unit_last = ({1'b0, r_q} + 5'd1 == rows) && ({1'b0, c_q} + 5'd1 == cols);

  assign rsp_o.bmu_row = br_q[3:0];
  assign rsp_o.bmu_col = bc_q[3:0];
  assign rsp_o.bmu_distance_sq = best_q;
  assign rsp_o.weights_updated = (req_q.cmd == CMD_TRAIN);
endmodule
`default_nettype wire

@@ sv/som_bmu_search_and_update_unit.sv @@
// A weight write, an unused command or a non-final observation element raises busy only
// while in ST_ALPHA. A final element holds busy while every unit of the grid in use is
// searched; training also waits in ST_ALPHA for the alpha division and then updates every
// weight of the grid in use. A new request is taken only while busy is low.
// result_valid_o strobes for one cycle, in the first cycle that busy is low; the receiver cannot stall.
// Reset clears control and sets the configuration to its defaults; weight memory holds no reset value.
`default_nettype none
`include "som_bmu_search_and_update_unit_defines.svh"
module som_bmu_search_and_update_unit import som_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  input  req_t       req_i,
  output logic       result_valid_o,
  output rsp_t       result_o,
  input  wire logic  cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic [4:0] rows_q, cols_q, dim_q;
  logic [15:0] iters_q, decay_q;
  ctl_t ctl;
  sts_t sts;
  rsp_t rsp;
  logic valid_q;
  rsp_t res_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd16; cols_q <= 5'd16; dim_q <= 5'd16;
      iters_q <= 16'd1; decay_q <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROWS:  rows_q <= cfg_data_i[4:0];
        REG_COLS:  cols_q <= cfg_data_i[4:0];
        REG_DIM:   dim_q <= cfg_data_i[4:0];
        REG_ITERS: iters_q <= cfg_data_i;
        REG_DECAY: decay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  som_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .busy_o(busy), .ctl_o(ctl)
  );

  som_dp u_dp (
    .clk_i, .rst_ni, .req_i, .rows_i(rows_q), .cols_i(cols_q), .dim_i(dim_q),
    .iters_i(iters_q), .decay_i(decay_q), .ctl_i(ctl), .sts_o(sts), .rsp_o(rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl.emit;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      res_q <= rsp;
    end
  end
  assign result_valid_o = valid_q;
  assign result_o = res_q;

  `SOM_ASSERT_NEXT(a_result_single, clk_i, rst_ni, result_valid_o, !result_valid_o,
    "result strobe lasted more than one cycle")
  `SOM_ASSERT_IMP(a_emit_busy, clk_i, rst_ni, ctl.emit, busy,
    "result produced while idle")
  `SOM_ASSERT_IMP(a_no_start_result, clk_i, rst_ni, result_valid_o, !busy,
    "result strobe while still busy")
endmodule
`default_nettype wire
